// ===== hw/rtl/ofsp_pkg.sv =====
// ============================================================================
// ofsp_pkg
// Shared constants for the object file section parser: section header codes,
// parse step codes, record kinds and field widths.
// ============================================================================
package ofsp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned KIND_W  = 2;

    localparam logic [WORD_W-1:0] HDR_CODE   = 16'hCADE;
    localparam logic [WORD_W-1:0] HDR_DATA   = 16'hDADA;
    localparam logic [WORD_W-1:0] HDR_SYMBOL = 16'hC3B7;

    localparam logic [STEP_W-1:0] STEP_HEADER  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ADDRESS = 3'd1;
    localparam logic [STEP_W-1:0] STEP_COUNT   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WORDS   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LABEL   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SKIP    = 3'd5;

    localparam logic [KIND_W-1:0] KIND_MEM_WORD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LABEL_CHAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY_LABEL = 2'd2;

endpackage

// ===== hw/rtl/object_file_section_parser.sv =====
// ============================================================================
// object_file_section_parser
// Byte-stream parser for object files: turns code, data and symbol sections
// into memory-write and label records.
// ============================================================================
// Usage:
//   Input channel s_*: one raw file byte per item in s_tdata[7:0].
//   Output channel m_*: one record per item.
//     m_tdata  = {value, target_address}, m_tuser = kind, m_tlast = last
//     record of the current section.
//   Each accepted byte lands in an input register; the parse logic then
//   updates the section state and, when the byte completes a record, loads
//   the output register. Throughput is one byte per cycle while the
//   receiver does not stall, set by the single parse stage between the
//   input and output registers.
//   Bytes that produce no record (header, address, count, high bytes,
//   skipped bytes) still pass through the parse stage in order.
//   When the receiver stalls with a record held, the parse stage holds and
//   s_tready drops once the input register is full; nothing is lost.
//   Reset clears both registers' valid flags and returns the parser to
//   expecting a header word at the high byte.
// ============================================================================
module object_file_section_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    // output records
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] target_address, [31:16] value
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast      // last record of the section
);

    // input register
    logic                              in_valid_reg;
    logic [ofsp_pkg::BYTE_W-1:0]       in_byte_reg;

    // parse state
    logic                              byte_phase_reg, byte_phase_next;
    logic [ofsp_pkg::BYTE_W-1:0]       high_byte_reg, high_byte_next;
    logic [ofsp_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [ofsp_pkg::WORD_W-1:0]       header_reg, header_next;
    logic [ofsp_pkg::WORD_W-1:0]       address_reg, address_next;
    logic [ofsp_pkg::COUNT_W-1:0]      remaining_reg, remaining_next;
    logic [ofsp_pkg::WORD_W-1:0]       offset_reg, offset_next;

    // output register
    logic                              out_valid_reg;
    logic [ofsp_pkg::KIND_W-1:0]       out_kind_reg;
    logic [ofsp_pkg::WORD_W-1:0]       out_addr_reg;
    logic [ofsp_pkg::WORD_W-1:0]       out_value_reg;
    logic                              out_last_reg;

    // parse stage results
    logic                              emit;
    logic [ofsp_pkg::KIND_W-1:0]       emit_kind;
    logic [ofsp_pkg::WORD_W-1:0]       emit_addr;
    logic [ofsp_pkg::WORD_W-1:0]       emit_value;
    logic                              emit_last;

    logic                              out_free;
    logic                              advance;
    logic [ofsp_pkg::WORD_W-1:0]       word;
    logic [ofsp_pkg::COUNT_W-1:0]      count_dec;
    logic                              is_code_data;

    // The parse stage runs whenever a byte is held and the output register can take a record.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign word      = {high_byte_reg, in_byte_reg};
    assign count_dec = remaining_reg - ofsp_pkg::COUNT_W'(1);
    assign is_code_data = (header_reg == ofsp_pkg::HDR_CODE) ||
                          (header_reg == ofsp_pkg::HDR_DATA);

    always_comb
    begin
        byte_phase_next = byte_phase_reg;
        high_byte_next  = high_byte_reg;
        step_next       = step_reg;
        header_next     = header_reg;
        address_next    = address_reg;
        remaining_next  = remaining_reg;
        offset_next     = offset_reg;
        emit            = 1'b0;
        emit_kind       = ofsp_pkg::KIND_MEM_WORD;
        emit_addr       = address_reg;
        emit_value      = '0;
        emit_last       = 1'b0;

        if (step_reg == ofsp_pkg::STEP_LABEL)
        begin
            // label bytes are taken raw, one per item
            remaining_next = count_dec;
            emit           = 1'b1;
            emit_kind      = ofsp_pkg::KIND_LABEL_CHAR;
            emit_value     = {{(ofsp_pkg::WORD_W-ofsp_pkg::BYTE_W){1'b0}}, in_byte_reg};
            emit_last      = (count_dec == '0);
            if (count_dec == '0)
                step_next = ofsp_pkg::STEP_HEADER;
        end
        else if (step_reg == ofsp_pkg::STEP_SKIP)
        begin
            // drop unknown section bytes
            remaining_next = count_dec;
            if (count_dec == '0)
                step_next = ofsp_pkg::STEP_HEADER;
        end
        else if (!byte_phase_reg)
        begin
            high_byte_next  = in_byte_reg;
            byte_phase_next = 1'b1;
            // unreachable step codes fall back to header
            if (step_reg > ofsp_pkg::STEP_SKIP)
                step_next = ofsp_pkg::STEP_HEADER;
        end
        else
        begin
            byte_phase_next = 1'b0;
            unique case (step_reg)
                ofsp_pkg::STEP_ADDRESS:
                begin
                    address_next = word;
                    step_next    = ofsp_pkg::STEP_COUNT;
                end
                ofsp_pkg::STEP_COUNT:
                begin
                    offset_next = '0;
                    if (is_code_data)
                    begin
                        remaining_next = {1'b0, word};
                        step_next = (word == '0) ? ofsp_pkg::STEP_HEADER
                                                 : ofsp_pkg::STEP_WORDS;
                    end
                    else if (header_reg == ofsp_pkg::HDR_SYMBOL)
                    begin
                        remaining_next = {1'b0, word};
                        if (word == '0)
                        begin
                            step_next = ofsp_pkg::STEP_HEADER;
                            emit      = 1'b1;
                            emit_kind = ofsp_pkg::KIND_EMPTY_LABEL;
                            emit_last = 1'b1;
                        end
                        else
                        begin
                            step_next = ofsp_pkg::STEP_LABEL;
                        end
                    end
                    else
                    begin
                        // skip two bytes per counted word
                        remaining_next = {word, 1'b0};
                        step_next = (word == '0) ? ofsp_pkg::STEP_HEADER
                                                 : ofsp_pkg::STEP_SKIP;
                    end
                end
                ofsp_pkg::STEP_WORDS:
                begin
                    remaining_next = count_dec;
                    emit           = 1'b1;
                    emit_kind      = ofsp_pkg::KIND_MEM_WORD;
                    emit_addr      = address_reg + offset_reg;
                    emit_value     = word;
                    emit_last      = (count_dec == '0);
                    offset_next    = offset_reg + ofsp_pkg::WORD_W'(1);
                    if (count_dec == '0)
                        step_next = ofsp_pkg::STEP_HEADER;
                end
                default:
                begin
                    // header word (also any stray step code)
                    header_next = word;
                    step_next   = ofsp_pkg::STEP_ADDRESS;
                end
            endcase
        end
    end

    // input register: hold the byte until the parse stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // parse state: advance once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg <= 1'b0;
            high_byte_reg  <= '0;
            step_reg       <= ofsp_pkg::STEP_HEADER;
            header_reg     <= '0;
            address_reg    <= '0;
            remaining_reg  <= '0;
            offset_reg     <= '0;
        end
        else if (advance)
        begin
            byte_phase_reg <= byte_phase_next;
            high_byte_reg  <= high_byte_next;
            step_reg       <= step_next;
            header_reg     <= header_next;
            address_reg    <= address_next;
            remaining_reg  <= remaining_next;
            offset_reg     <= offset_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_addr_reg  <= emit_addr;
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
